### src/biou_pkg.sv
`timescale 1ns / 1ps
package biou_pkg;

    localparam int unsigned ENTRIES_DEF    = 16;
    localparam int unsigned COORD_BITS_DEF = 16;
    localparam int unsigned FRAC_BITS_DEF  = 15;
    localparam int unsigned SCORE_W        = 17;
    localparam int unsigned SLOT_W         = 4;
    localparam int unsigned ADDR_W         = 5;

    localparam logic [1:0] CMD_STORE = 2'd0;
    localparam logic [1:0] CMD_QUERY = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [ADDR_W-1:0] REG_USE_AREA   = 5'd0;
    localparam logic [ADDR_W-1:0] REG_USE_X      = 5'd4;
    localparam logic [ADDR_W-1:0] REG_USE_Y      = 5'd8;
    localparam logic [ADDR_W-1:0] REG_THRESHOLD  = 5'd12;
    localparam logic [ADDR_W-1:0] REG_KEEP_CLASS = 5'd16;

    localparam logic [SCORE_W-1:0] THRESHOLD_RESET = 17'd3277;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  slot;
        logic [15:0] box_x;
        logic [15:0] box_y;
        logic [15:0] box_width;
        logic [15:0] box_height;
        logic [15:0] probability;
        logic        label_known;
    } in_word_t;

    typedef struct packed {
        logic [3:0]  best_slot;
        logic [16:0] best_score;
        logic        accept;
    } out_word_t;

    typedef struct packed {
        logic use_area;
        logic use_x;
        logic use_y;
    } term_cfg_t;

endpackage

### src/box_iou_best_match_core.sv
`timescale 1ns / 1ps
// Box IoU best match.
// Input channel in_valid/in_stall carries a word with cmd: store writes a
// table slot, clear empties the table, query scores the box against every
// valid slot. Only a query gives an output word on out_valid/out_stall.
// The table is a ring of cells that rotates one slot per step; every query
// makes one full turn of ENTRIES steps, so slot order is kept.
// A slot that is empty or disjoint passes only S_GEOM and S_NEXT; otherwise
// it also passes S_AREA and, for each enabled term, one run of the one shared
// bit-serial divider. A store makes one full turn of the ring, and a clear
// empties the table as the word is taken. One word is in work at a time.
// Reset empties the table and loads the register defaults. When the receiver
// stalls, the result is held in the output register and no new word is taken
// until it has gone. Registers at byte addresses 0,4,8,12,16 via APB;
// pready is always high and writes should only be made while the block is idle.
module box_iou_best_match_core #(
    parameter int unsigned ENTRIES    = biou_pkg::ENTRIES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  biou_pkg::in_word_t          in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output biou_pkg::out_word_t         out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [biou_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import biou_pkg::*;

    localparam int unsigned COORD_BITS = COORD_BITS_DEF;
    localparam int unsigned FRAC_BITS  = FRAC_BITS_DEF;
    localparam int unsigned CW    = COORD_BITS;
    localparam int unsigned EW    = CW + 1;
    localparam int unsigned AW    = 2 * EW + 1;
    localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
    localparam int unsigned QW    = FRAC_BITS + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_STORE, S_GEOM, S_AREA, S_DIV_A, S_DIV_X, S_DIV_Y,
        S_WAIT, S_NEXT, S_OUT
    } state_t;

    // configuration
    term_cfg_t          terms_reg;
    logic [SCORE_W-1:0] thr_reg;
    logic               keep_reg;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            terms_reg <= '{use_area: 1'b0, use_x: 1'b1, use_y: 1'b0};
            thr_reg   <= THRESHOLD_RESET;
            keep_reg  <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (paddr)
                REG_USE_AREA:   terms_reg.use_area <= pwdata[0];
                REG_USE_X:      terms_reg.use_x <= pwdata[0];
                REG_USE_Y:      terms_reg.use_y <= pwdata[0];
                REG_THRESHOLD:  thr_reg <= pwdata[SCORE_W-1:0];
                REG_KEEP_CLASS: keep_reg <= pwdata[0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            REG_USE_AREA:   prdata = {31'd0, terms_reg.use_area};
            REG_USE_X:      prdata = {31'd0, terms_reg.use_x};
            REG_USE_Y:      prdata = {31'd0, terms_reg.use_y};
            REG_THRESHOLD:  prdata = {15'd0, thr_reg};
            REG_KEEP_CLASS: prdata = {31'd0, keep_reg};
            default:        prdata = '0;
        endcase
    end

    // cell ring
    state_t            state_reg;
    in_word_t          q_reg;
    logic              shift, clear, load_last;
    logic [CNT_W-1:0]  pos_reg;
    logic [IDX_W-1:0]  idx_reg;

    logic                 v_o [ENTRIES];
    logic [4*CW-1:0]      b_o [ENTRIES];
    logic [15:0]          p_o [ENTRIES];

    logic [4*CW-1:0] q_box;
    assign q_box = {q_reg.box_x[CW-1:0], q_reg.box_y[CW-1:0],
                    q_reg.box_width[CW-1:0], q_reg.box_height[CW-1:0]};

    // A store turns the ring once; the new entry enters the tail in place of
    // the target slot as that slot leaves the head.
    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++)
        begin : g_cell
            logic          vi;
            logic [4*CW-1:0] bi;
            logic [15:0]   pi;
            if (g == ENTRIES - 1)
            begin : g_tail
                assign vi = load_last ? 1'b1 : v_o[0];
                assign bi = load_last ? q_box : b_o[0];
                assign pi = load_last ? q_reg.probability : p_o[0];
            end
            else
            begin : g_body
                assign vi = v_o[g+1];
                assign bi = b_o[g+1];
                assign pi = p_o[g+1];
            end
            biou_cell #(.COORD_BITS(CW)) u_cell (
                .clk(clk), .rst_n(rst_n), .shift(shift), .clear(clear),
                .load(1'b0), .valid_in(vi), .box_in(bi), .prob_in(pi),
                .valid_out(v_o[g]), .box_out(b_o[g]), .prob_out(p_o[g])
            );
        end
    endgenerate

    // geometry of head cell against query
    logic [CW-1:0] cx, cy, cw, ch;
    assign {cx, cy, cw, ch} = b_o[0];

    logic [EW-1:0] ce_x, ce_y, qe_x, qe_y, lo_x, lo_y, hi_x, hi_y;
    always_comb
    begin
        ce_x = EW'(cx) + EW'(cw);
        ce_y = EW'(cy) + EW'(ch);
        qe_x = EW'(q_reg.box_x[CW-1:0]) + EW'(q_reg.box_width[CW-1:0]);
        qe_y = EW'(q_reg.box_y[CW-1:0]) + EW'(q_reg.box_height[CW-1:0]);
        lo_x = (cx > q_reg.box_x[CW-1:0]) ? EW'(cx) : EW'(q_reg.box_x[CW-1:0]);
        lo_y = (cy > q_reg.box_y[CW-1:0]) ? EW'(cy) : EW'(q_reg.box_y[CW-1:0]);
        hi_x = (ce_x < qe_x) ? ce_x : qe_x;
        hi_y = (ce_y < qe_y) ? ce_y : qe_y;
    end

    logic [EW-1:0] ovx_reg, ovy_reg;
    logic [AW-1:0] ov_reg, ca_reg, qa_reg;
    logic [SCORE_W-1:0] sum_reg, best_reg;
    logic [IDX_W-1:0]   bidx_reg;
    logic [15:0]        bprob_reg;

    // divider
    logic          div_start, div_done;
    logic [AW-1:0] div_num, div_den;
    logic [QW-1:0] div_q;

    biou_div #(.NUM_W(AW), .FRAC_BITS(FRAC_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
        .den(div_den), .done(div_done), .quo(div_q)
    );

    state_t        after_reg;
    out_word_t     out_reg;
    logic          outv_reg;
    logic [SLOT_W-1:0] tgt;

    assign tgt = q_reg.slot;
    assign in_stall  = (state_reg != S_IDLE) || outv_reg;
    assign out_valid = outv_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        shift     = 1'b0;
        clear     = 1'b0;
        load_last = 1'b0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        if (state_reg == S_STORE)
        begin
            shift     = 1'b1;
            load_last = (pos_reg == CNT_W'(tgt));
        end
        if (state_reg == S_NEXT)
            shift = 1'b1;
        if (state_reg == S_IDLE && in_valid && !in_stall
            && in_data.cmd == CMD_CLEAR)
            clear = 1'b1;
        if (state_reg == S_DIV_A)
        begin
            div_start = 1'b1;
            div_num   = ov_reg;
            div_den   = ca_reg + qa_reg - ov_reg;
        end
        if (state_reg == S_DIV_X)
        begin
            div_start = 1'b1;
            div_num   = AW'(ovx_reg);
            div_den   = AW'(cw) + AW'(q_reg.box_width[CW-1:0]) - AW'(ovx_reg);
        end
        if (state_reg == S_DIV_Y)
        begin
            div_start = 1'b1;
            div_num   = AW'(ovy_reg);
            div_den   = AW'(ch) + AW'(q_reg.box_height[CW-1:0]) - AW'(ovy_reg);
        end
    end

    logic [SCORE_W-1:0] ep_cmp;
    logic [15:0]        ep;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            outv_reg  <= 1'b0;
            pos_reg   <= '0;
        end
        else
        begin
            if (outv_reg && !out_stall)
                outv_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && !in_stall)
                    begin
                        q_reg   <= in_data;
                        pos_reg <= '0;
                        if (in_data.cmd == CMD_STORE
                            && 32'(in_data.slot) < ENTRIES)
                            state_reg <= S_STORE;
                        else if (in_data.cmd == CMD_QUERY)
                        begin
                            sum_reg   <= '0;
                            best_reg  <= '0;
                            bidx_reg  <= '0;
                            bprob_reg <= '0;
                            idx_reg   <= '0;
                            state_reg <= S_GEOM;
                        end
                    end
                end
                S_STORE:
                begin
                    pos_reg <= pos_reg + 1'b1;
                    if (pos_reg == CNT_W'(ENTRIES - 1))
                        state_reg <= S_IDLE;
                end
                S_GEOM:
                begin
                    sum_reg  <= '0;
                    ovx_reg  <= hi_x - lo_x;
                    ovy_reg  <= hi_y - lo_y;
                    ca_reg   <= AW'(cw) * AW'(ch);
                    qa_reg   <= AW'(q_reg.box_width[CW-1:0])
                                * AW'(q_reg.box_height[CW-1:0]);
                    if (!v_o[0] || (hi_x < lo_x) || (hi_y < lo_y))
                        state_reg <= S_NEXT;
                    else
                        state_reg <= S_AREA;
                end
                S_AREA:
                begin
                    ov_reg <= AW'(ovx_reg) * AW'(ovy_reg);
                    if (terms_reg.use_area)
                        state_reg <= S_DIV_A;
                    else if (terms_reg.use_x)
                        state_reg <= S_DIV_X;
                    else if (terms_reg.use_y)
                        state_reg <= S_DIV_Y;
                    else
                        state_reg <= S_NEXT;
                end
                S_DIV_A:
                begin
                    after_reg <= terms_reg.use_x ? S_DIV_X
                               : (terms_reg.use_y ? S_DIV_Y : S_NEXT);
                    state_reg <= S_WAIT;
                end
                S_DIV_X:
                begin
                    after_reg <= terms_reg.use_y ? S_DIV_Y : S_NEXT;
                    state_reg <= S_WAIT;
                end
                S_DIV_Y:
                begin
                    after_reg <= S_NEXT;
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (div_done)
                    begin
                        sum_reg   <= sum_reg + SCORE_W'(div_q);
                        state_reg <= after_reg;
                        if (after_reg == S_NEXT
                            && sum_reg + SCORE_W'(div_q) > best_reg)
                        begin
                            best_reg  <= sum_reg + SCORE_W'(div_q);
                            bidx_reg  <= idx_reg;
                            bprob_reg <= p_o[0];
                        end
                    end
                end
                S_NEXT:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (32'(idx_reg) == ENTRIES - 1)
                        state_reg <= S_OUT;
                    else
                        state_reg <= S_GEOM;
                end
                S_OUT:
                begin
                    out_reg.best_slot  <= SLOT_W'(bidx_reg);
                    out_reg.best_score <= best_reg;
                    out_reg.accept     <= (best_reg > thr_reg)
                                          && q_reg.label_known
                                          && (ep <= q_reg.probability);
                    outv_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign ep     = keep_reg ? bprob_reg : 16'd0;
    assign ep_cmp = SCORE_W'(ep);

`ifndef SYNTHESIS
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("word taken while busy");
    a_out_from_query: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(outv_reg) |-> $past(state_reg) == S_OUT)
        else $error("result without query");
    a_score_bound: assert property (@(posedge clk) disable iff (!rst_n)
        outv_reg |-> (out_reg.best_score != '0 || out_reg.best_slot == '0))
        else $error("zero score with nonzero slot");
    a_ep_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !keep_reg |-> ep_cmp == '0)
        else $error("cluster probability leaked");
`endif
endmodule

### src/biou_div.sv
`timescale 1ns / 1ps
// Restoring fractional divider, one quotient bit per cycle.
module biou_div #(
    parameter int unsigned NUM_W = 48,
    parameter int unsigned FRAC_BITS = 15
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [NUM_W-1:0] den,
    output logic             done,
    output logic [FRAC_BITS:0] quo
);
    localparam int unsigned CNT_W = $clog2(FRAC_BITS + 1);

    logic [NUM_W:0]     rem_reg, rem_next;
    logic [NUM_W-1:0]   den_reg;
    logic [FRAC_BITS:0] quo_reg, quo_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg, done_reg;
    logic [NUM_W:0]     shifted;

    always_comb
    begin
        shifted  = {rem_reg[NUM_W-1:0], 1'b0};
        rem_next = shifted;
        quo_next = {quo_reg[FRAC_BITS-1:0], 1'b0};
        if (shifted >= {1'b0, den_reg})
        begin
            rem_next    = shifted - {1'b0, den_reg};
            quo_next[0] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                den_reg <= den;
                rem_reg <= {1'b0, num};
                quo_reg <= '0;
                cnt_reg <= '0;
                if (den == '0)
                    done_reg <= 1'b1;
                else if (num >= den)
                begin
                    quo_reg  <= {1'b1, {FRAC_BITS{1'b0}}};
                    done_reg <= 1'b1;
                end
                else
                    busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(FRAC_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
endmodule

### src/biou_cell.sv
`timescale 1ns / 1ps
// One table slot. Slots form a rotating ring; cell 0 presents its entry.
module biou_cell #(
    parameter int unsigned COORD_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    shift,
    input  logic                    clear,
    input  logic                    load,
    input  logic                    valid_in,
    input  logic [4*COORD_BITS-1:0] box_in,
    input  logic [15:0]             prob_in,
    output logic                    valid_out,
    output logic [4*COORD_BITS-1:0] box_out,
    output logic [15:0]             prob_out
);
    logic                    valid_reg;
    logic [4*COORD_BITS-1:0] box_reg;
    logic [15:0]             prob_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (clear)
            valid_reg <= 1'b0;
        else if (shift || load)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (shift || load)
        begin
            box_reg  <= box_in;
            prob_reg <= prob_in;
        end
    end

    assign valid_out = valid_reg;
    assign box_out   = box_reg;
    assign prob_out  = prob_reg;
endmodule

### dv/tb_box_iou_best_match_core.sv
`timescale 1ns / 1ps
module tb_box_iou_best_match_core;
    import biou_pkg::*;

    // Behavioural image of the match table and the scorer.
    class match_scoreboard;
        bit          tab_valid [16];
        logic [15:0] tab_x [16];
        logic [15:0] tab_y [16];
        logic [15:0] tab_w [16];
        logic [15:0] tab_h [16];
        logic [15:0] tab_prob [16];
        bit          use_area;
        bit          use_x;
        bit          use_y;
        logic [16:0] threshold;
        bit          keep_class;
        out_word_t   pending_matches [$];
        int          errors;
        int          checked;

        function new();
            for (int i = 0; i < 16; i++)
            begin
                tab_valid[i] = 0;
            end
            use_area = 0;
            use_x = 1;
            use_y = 0;
            threshold = THRESHOLD_RESET;
            keep_class = 0;
            errors = 0;
            checked = 0;
        endfunction

        function automatic logic [63:0] ratio_q15(logic [63:0] num, logic [63:0] den);
            if (den == 0)
                return 0;
            if (num >= den)
                return 64'd32768;
            return (num << 15) / den;
        endfunction

        function automatic logic [63:0] pair_score(int i, in_word_t q);
            logic [63:0] lo_x, lo_y, hi_x, hi_y, ov_x, ov_y, ov, sum;
            lo_x = (tab_x[i] > q.box_x) ? tab_x[i] : q.box_x;
            lo_y = (tab_y[i] > q.box_y) ? tab_y[i] : q.box_y;
            hi_x = 64'(tab_x[i]) + tab_w[i];
            if (64'(q.box_x) + q.box_width < hi_x)
                hi_x = 64'(q.box_x) + q.box_width;
            hi_y = 64'(tab_y[i]) + tab_h[i];
            if (64'(q.box_y) + q.box_height < hi_y)
                hi_y = 64'(q.box_y) + q.box_height;
            if (hi_x < lo_x || hi_y < lo_y)
                return 0;
            ov_x = hi_x - lo_x;
            ov_y = hi_y - lo_y;
            sum = 0;
            if (use_area)
            begin
                ov = ov_x * ov_y;
                sum += ratio_q15(ov, 64'(tab_w[i]) * tab_h[i]
                                 + 64'(q.box_width) * q.box_height - ov);
            end
            if (use_x)
                sum += ratio_q15(ov_x, 64'(tab_w[i]) + q.box_width - ov_x);
            if (use_y)
                sum += ratio_q15(ov_y, 64'(tab_h[i]) + q.box_height - ov_y);
            return sum;
        endfunction

        function void note_word(in_word_t w);
            logic [63:0] best_sc, s, ep;
            int best;
            out_word_t r;
            case (w.cmd)
                CMD_STORE:
                begin
                    tab_valid[w.slot] = 1;
                    tab_x[w.slot] = w.box_x;
                    tab_y[w.slot] = w.box_y;
                    tab_w[w.slot] = w.box_width;
                    tab_h[w.slot] = w.box_height;
                    tab_prob[w.slot] = w.probability;
                end
                CMD_CLEAR:
                    for (int i = 0; i < 16; i++)
                    begin
                        tab_valid[i] = 0;
                    end
                CMD_QUERY:
                begin
                    best = 0;
                    best_sc = 0;
                    for (int i = 0; i < 16; i++)
                    begin
                        if (tab_valid[i])
                        begin
                            s = pair_score(i, w);
                            if (s > best_sc)
                            begin
                                best_sc = s;
                                best = i;
                            end
                        end
                    end
                    ep = keep_class ? 64'(tab_prob[best]) : 64'd0;
                    r.best_slot = best[3:0];
                    r.best_score = best_sc[16:0];
                    r.accept = (best_sc > threshold) && w.label_known
                               && (ep <= w.probability);
                    pending_matches = {pending_matches, r};
                end
                default: ;
            endcase
        endfunction

        function void report(string what, logic [31:0] want, logic [31:0] got);
            errors++;
            $display("MISMATCH result %0d %s: expected %0d got %0d",
                     checked, what, want, got);
        endfunction

        function void check_match(out_word_t got);
            out_word_t exp_w;
            checked++;
            if (pending_matches.size() == 0)
            begin
                report("result with no query waiting", 0, 32'(got.best_score));
                return;
            end
            exp_w = pending_matches.pop_front();
            if (got.best_slot !== exp_w.best_slot)
                report("best_slot", 32'(exp_w.best_slot), 32'(got.best_slot));
            if (got.best_score !== exp_w.best_score)
                report("best_score", 32'(exp_w.best_score), 32'(got.best_score));
            if (got.accept !== exp_w.accept)
                report("accept", 32'(exp_w.accept), 32'(got.accept));
        endfunction
    endclass

    logic      clk = 0;
    logic      rst_n = 0;
    logic      in_valid = 0;
    logic      in_stall;
    in_word_t  in_data = '0;
    logic      out_valid;
    logic      out_stall = 0;
    out_word_t out_data;
    logic      psel = 0;
    logic      penable = 0;
    logic      pwrite = 0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic      pready;

    match_scoreboard sb = new();
    int  cycles = 0;
    int  queries_sent = 0;
    bit  idle_off = 0;
    localparam int CYCLE_LIMIT = 10000000;

    box_iou_best_match_core dut (.*);

    always
    begin
        #6 clk = 1;
        #6 clk = 0;
    end

    function automatic int random_gap();
        if (idle_off)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 120);
        return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
    endfunction

    always @(posedge clk)
    begin
        cycles++;
        if (in_valid && !in_stall)
            sb.note_word(in_data);
        if (out_valid && !out_stall)
            sb.check_match(out_data);
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver: random stalls with quiet stretches.
    initial
    begin
        int n;
        forever
        begin
            @(negedge clk);
            n = random_gap();
            if (n != 0)
            begin
                out_stall <= 1;
                repeat (n) @(negedge clk);
                out_stall <= 0;
            end
        end
    end

    task automatic send_word(in_word_t w);
        int n;
        n = random_gap();
        if (n != 0)
        begin
            in_valid <= 0;
            repeat (n) @(negedge clk);
        end
        in_data <= w;
        in_valid <= 1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        if (w.cmd == CMD_QUERY)
            queries_sent++;
    endtask

    task automatic write_reg(logic [ADDR_W-1:0] addr, logic [31:0] value);
        @(negedge clk);
        psel <= 1;
        pwrite <= 1;
        paddr <= addr;
        pwdata <= value;
        @(negedge clk);
        penable <= 1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        case (addr)
            REG_USE_AREA:   sb.use_area = value[0];
            REG_USE_X:      sb.use_x = value[0];
            REG_USE_Y:      sb.use_y = value[0];
            REG_THRESHOLD:  sb.threshold = value[16:0];
            REG_KEEP_CLASS: sb.keep_class = value[0];
            default: ;
        endcase
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.pending_matches.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    function automatic in_word_t make_word(logic [1:0] cmd);
        in_word_t w;
        w.cmd = cmd;
        w.slot = 4'($urandom_range(0, 15));
        // Mostly boxes in a small region so that overlaps are common.
        if ($urandom_range(0, 9) == 0)
        begin
            w.box_x = 16'($urandom);
            w.box_y = 16'($urandom);
            w.box_width = 16'($urandom);
            w.box_height = 16'($urandom);
        end
        else
        begin
            w.box_x = 16'($urandom_range(0, 200));
            w.box_y = 16'($urandom_range(0, 200));
            w.box_width = 16'($urandom_range(0, 120));
            w.box_height = 16'($urandom_range(0, 120));
        end
        w.probability = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 32768));
        w.label_known = ($urandom_range(0, 4) != 0);
        return w;
    endfunction

    function automatic in_word_t box_word(logic [1:0] cmd, int slot, int x, int y,
                                          int wd, int ht, int prob, bit known);
        in_word_t w;
        w.cmd = cmd;
        w.slot = 4'(slot);
        w.box_x = 16'(x);
        w.box_y = 16'(y);
        w.box_width = 16'(wd);
        w.box_height = 16'(ht);
        w.probability = 16'(prob);
        w.label_known = known;
        return w;
    endfunction

    task automatic random_phase(int count);
        int r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                send_word(make_word(CMD_STORE));
            else if (r < 93)
                send_word(make_word(CMD_QUERY));
            else if (r < 97)
                send_word(make_word(CMD_CLEAR));
            else
                send_word(make_word(2'd3));
        end
    endtask

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n = 1;

        // Directed: empty table, extremes, touching and disjoint boxes, ties.
        idle_off = 1;
        send_word(box_word(CMD_QUERY, 0, 10, 10, 5, 5, 100, 1));
        send_word(box_word(CMD_STORE, 3, 10, 10, 20, 20, 200, 1));
        send_word(box_word(CMD_STORE, 5, 10, 10, 20, 20, 100, 0));
        send_word(box_word(CMD_QUERY, 0, 10, 10, 20, 20, 300, 1));
        send_word(box_word(CMD_QUERY, 0, 30, 10, 5, 5, 300, 1));
        send_word(box_word(CMD_QUERY, 0, 31, 10, 5, 5, 300, 0));
        send_word(box_word(CMD_STORE, 15, 0, 0, 0, 0, 65535, 1));
        send_word(box_word(CMD_QUERY, 0, 0, 0, 0, 0, 0, 1));
        send_word(box_word(CMD_STORE, 0, 65535, 65535, 65535, 65535, 32768, 1));
        send_word(box_word(CMD_QUERY, 9, 65535, 65535, 65535, 65535, 65535, 1));
        send_word(box_word(2'd3, 15, 1, 2, 3, 4, 5, 1));
        send_word(box_word(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        send_word(box_word(CMD_QUERY, 0, 10, 10, 20, 20, 300, 1));
        drain();

        write_reg(REG_USE_AREA, 1);
        write_reg(REG_USE_Y, 1);
        write_reg(REG_KEEP_CLASS, 1);
        write_reg(REG_THRESHOLD, 0);
        send_word(box_word(CMD_STORE, 2, 0, 0, 40, 40, 100, 1));
        send_word(box_word(CMD_STORE, 7, 20, 20, 40, 40, 32768, 1));
        send_word(box_word(CMD_QUERY, 0, 20, 20, 40, 40, 50, 1));
        send_word(box_word(CMD_QUERY, 0, 20, 20, 40, 40, 32768, 1));
        send_word(box_word(CMD_QUERY, 0, 0, 0, 40, 40, 100, 1));
        drain();
        idle_off = 0;

        write_reg(REG_THRESHOLD, 98304);
        random_phase(300);
        drain();
        write_reg(REG_USE_AREA, 0);
        write_reg(REG_USE_X, 0);
        write_reg(REG_USE_Y, 0);
        write_reg(REG_THRESHOLD, 'h1FFFF);
        random_phase(150);
        drain();
        for (int p = 0; p < 7; p++)
        begin
            write_reg(REG_USE_AREA, $urandom_range(0, 1));
            write_reg(REG_USE_X, $urandom_range(0, 1));
            write_reg(REG_USE_Y, $urandom_range(0, 1));
            write_reg(REG_THRESHOLD, (p == 0) ? 0 : $urandom_range(0, 40000));
            write_reg(REG_KEEP_CLASS, $urandom_range(0, 1));
            // One phase runs without any idling.
            idle_off = (p == 3);
            random_phase(200);
            drain();
        end
        idle_off = 0;

        $display("Sent %0d queries and checked %0d results under eleven register settings.",
                 queries_sent, sb.checked);
        if (sb.errors == 0 && sb.pending_matches.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### filelist.f
src/biou_pkg.sv
src/biou_div.sv
src/biou_cell.sv
src/box_iou_best_match_core.sv
dv/tb_box_iou_best_match_core.sv
